// ----- sv/bdlc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlc_pkg
// Types and constants shared by the push-button lamp dimmer level controller.
// ----------------------------------------------------------------------------
package bdlc_pkg;

  typedef struct packed {
    logic       bright_pressed;
    logic       dim_pressed;
    logic [9:0] sensor_level;
    logic [9:0] auto_level;
    logic [7:0] min_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lamp_level;
    logic [2:0] check_interval;
    logic       test_active;
  } out_item_t;

  typedef enum logic [1:0] {
    COMBO_IDLE   = 2'd0,
    COMBO_BOTH   = 2'd1,
    COMBO_BRIGHT = 2'd2,
    COMBO_TEST   = 2'd3
  } combo_t;

  localparam logic [1:0] CFG_MAX_BRIGHT    = 2'd0;
  localparam logic [1:0] CFG_SET_POINT     = 2'd1;
  localparam logic [1:0] CFG_AUTO_THRESHOLD = 2'd2;

  localparam logic [7:0] MAX_BRIGHT_RESET    = 8'd253;
  localparam logic [9:0] SET_POINT_RESET     = 10'd600;
  localparam logic [9:0] AUTO_THRESHOLD_RESET = 10'd500;
  localparam logic [7:0] LEVEL_RESET         = 8'd208;

  localparam logic [2:0] INTERVAL_TEST   = 3'd2;
  localparam logic [2:0] INTERVAL_NORMAL = 3'd3;
  localparam logic [2:0] INTERVAL_EXIT   = 3'd5;

  localparam logic [7:0] COMBO_TIMEOUT = 8'h60;
  localparam logic [7:0] TEST_PASSES   = 8'd255;

  localparam logic [5:0] STEP_RAMP_UP   = 6'd0;
  localparam logic [5:0] STEP_RAMP_DOWN = 6'd1;
  localparam logic [5:0] STEP_LAST     = 6'd30;

endpackage

// ----- sv/button_dimmer_level_controller_top.sv -----
// ----------------------------------------------------------------------------
// button_dimmer_level_controller_top
// Lamp level controller driven by periodic button checks.
// ----------------------------------------------------------------------------
// Each request is one button check and gives exactly one result. The block
// takes a new request in every cycle while no stalled result holds it: a
// request is captured in an input register, and one pass of logic then
// updates the lamp level, the test-mode combo detector and the test sequence
// and loads the result register. The input and result registers are the
// only buffers, so a stalled result holds the pipeline and in_stall follows
// out_stall one stage back. Configuration writes are taken at any time but
// should be made only while idle.
// ----------------------------------------------------------------------------
module button_dimmer_level_controller_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bdlc_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bdlc_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [9:0]           cfg_wdata
);

  import bdlc_pkg::*;

  logic [7:0] hi_r;
  logic [9:0] set_point_r;
  logic [9:0] auto_threshold_r;

  logic      in_v_r;
  in_item_t  in_r;
  logic      out_v_r;
  out_item_t out_r;
  logic      fire;

  logic [7:0] level_r,   level_nxt;
  combo_t     combo_r,   combo_nxt;
  logic [5:0] step_r,    step_nxt;
  logic [7:0] pass_r,    pass_nxt;
  logic       held_r,    held_nxt;
  logic [2:0] interval_r, interval_nxt;

  assign fire      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !fire;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r             <= MAX_BRIGHT_RESET;
      set_point_r      <= SET_POINT_RESET;
      auto_threshold_r <= AUTO_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_BRIGHT:     hi_r             <= cfg_wdata[7:0];
        CFG_SET_POINT:      set_point_r      <= cfg_wdata;
        CFG_AUTO_THRESHOLD: auto_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r.lamp_level     <= level_nxt;
      out_r.check_interval <= interval_nxt;
      out_r.test_active    <= (combo_nxt == COMBO_TEST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= LEVEL_RESET;
      combo_r    <= COMBO_IDLE;
      step_r     <= STEP_RAMP_UP;
      pass_r     <= 8'd0;
      held_r     <= 1'b0;
      interval_r <= INTERVAL_NORMAL;
    end else if (fire) begin
      level_r    <= level_nxt;
      combo_r    <= combo_nxt;
      step_r     <= step_nxt;
      pass_r     <= pass_nxt;
      held_r     <= held_nxt;
      interval_r <= interval_nxt;
    end
  end

  always_comb begin
    logic              both;
    logic              bright_only;
    logic              dim_only;
    logic              automatic_mode;
    logic signed [9:0] lv;
    logic signed [9:0] lo_s;
    logic signed [9:0] hi_s;
    logic [7:0]        lo;
    logic [7:0]        pass_inc;
    combo_t            stage;

    both           = in_r.bright_pressed && in_r.dim_pressed;
    bright_only    = in_r.bright_pressed && !in_r.dim_pressed;
    dim_only       = in_r.dim_pressed && !in_r.bright_pressed;
    automatic_mode = (in_r.auto_level >= auto_threshold_r);
    lo             = in_r.min_level;
    lo_s           = $signed({2'b00, lo});
    hi_s           = $signed({2'b00, hi_r});
    lv             = $signed({2'b00, level_r});
    pass_inc       = pass_r + 8'd1;
    stage          = combo_r;

    level_nxt    = level_r;
    combo_nxt    = combo_r;
    step_nxt     = step_r;
    pass_nxt     = pass_r;
    held_nxt     = held_r;
    interval_nxt = interval_r;

    if (combo_r == COMBO_TEST) begin
      interval_nxt = INTERVAL_TEST;
      if (dim_only) begin
        combo_nxt    = COMBO_IDLE;
        interval_nxt = INTERVAL_EXIT;
      end else begin
        case (step_r) inside
          STEP_RAMP_UP: begin
            if ({1'b0, level_r} + 9'd1 > {1'b0, hi_r}) begin
              level_nxt = hi_r;
              step_nxt  = STEP_RAMP_DOWN;
            end else begin
              level_nxt = level_r + 8'd1;
            end
          end
          STEP_RAMP_DOWN: begin
            if ({1'b0, level_r} <= {1'b0, lo} + 9'd1) begin
              level_nxt = hi_r;
              step_nxt  = 6'd2;
            end else begin
              level_nxt = level_r - 8'd1;
            end
          end
          [6'd2:6'd4]: step_nxt = step_r + 6'd1;
          [6'd5:6'd8]: begin
            step_nxt  = step_r + 6'd2;
            level_nxt = lo;
          end
          [6'd9:6'd12]: begin
            step_nxt  = step_r + 6'd3;
            level_nxt = hi_r;
          end
          [6'd13:6'd16]: begin
            step_nxt  = step_r + 6'd4;
            level_nxt = lo;
          end
          [6'd17:6'd20]: begin
            step_nxt  = step_r + 6'd5;
            level_nxt = hi_r;
          end
          [6'd21:6'd24]: begin
            step_nxt  = step_r + 6'd6;
            level_nxt = lo;
          end
          default: begin
            level_nxt = lo;
            step_nxt  = STEP_RAMP_UP;
            pass_nxt  = pass_inc;
            if (pass_inc == TEST_PASSES) begin
              combo_nxt    = COMBO_IDLE;
              interval_nxt = INTERVAL_NORMAL;
              pass_nxt     = 8'd0;
            end
          end
        endcase
      end
    end else begin
      if (combo_r != COMBO_IDLE) begin
        pass_nxt = pass_inc;
        if (pass_inc == COMBO_TIMEOUT) begin
          interval_nxt = INTERVAL_NORMAL;
          pass_nxt     = 8'd0;
          stage        = COMBO_IDLE;
        end
      end
      if (stage == COMBO_IDLE && both) begin
        stage = COMBO_BOTH;
      end
      if (stage == COMBO_BOTH && bright_only) begin
        stage = COMBO_BRIGHT;
      end
      if (stage == COMBO_BRIGHT && both) begin
        stage    = COMBO_TEST;
        step_nxt = STEP_RAMP_UP;
        lv       = lo_s;
        pass_nxt = 8'd0;
      end
      combo_nxt = stage;
      if (both) begin
        if (!held_r) begin
          held_nxt = 1'b1;
          lv       = (lv == lo_s) ? hi_s : lo_s;
        end
      end else begin
        held_nxt = 1'b0;
      end
      if (bright_only) begin
        lv = automatic_mode ? hi_s : lv + 10'sd1;
      end
      if (dim_only) begin
        lv = automatic_mode ? lo_s : lv - 10'sd1;
      end
      if (automatic_mode) begin
        if (in_r.sensor_level > set_point_r) begin
          lv = lv - 10'sd1;
        end else if (in_r.sensor_level < set_point_r) begin
          lv = lv + 10'sd1;
        end
      end
      if (lv > hi_s) begin
        lv = hi_s;
      end
      if (lv < lo_s) begin
        lv = lo_s;
      end
      level_nxt = lv[7:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_interval_outside_test: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_r.test_active |-> out_r.check_interval != INTERVAL_TEST)
    else $error("test interval reported outside test mode");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_LAST)
    else $error("test step out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(level_r) && $stable(combo_r) && $stable(pass_r)
              && $stable(held_r) && $stable(interval_r))
    else $error("state changed without a request");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_v_r && out_r.lamp_level == level_r)
    else $error("result missing after a processed request");
`endif

endmodule
